// ----- src/pqrm_pkg.sv -----
// ----------------------------------------------------------------------------
// pqrm_pkg: shared types and constants for the priority queue remove-max unit
// This package holds the queue depth, the field widths, the status codes, and
// the structs that the cells pass to each other.
// ----------------------------------------------------------------------------
package pqrm_pkg;

	localparam int DEPTH   = 16;
	localparam int PRIO_W  = 8;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 2;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// one stored entry
	typedef struct packed {
		logic              valid;
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] data;
	} entry_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              rem;
		logic [PRIO_W-1:0] prio;
		logic [DATA_W-1:0] data;
	} cell_op_t;

endpackage

// ----- src/priority_queue_remove_max_unit.sv -----
// ----------------------------------------------------------------------------
// priority_queue_remove_max_unit: bounded priority queue, remove highest first
// A row of DEPTH cells kept sorted by priority, oldest first among equals.
// Insert slots the word in place, remove pops cell 0 and shifts the row left.
//
//   channel  handshake           fields
//   in       in_valid/in_stall   cmd, priority_req, payload
//   out      out_valid/out_stall status, out_priority, out_payload
//
// One word per cycle while in_stall is low: the cells update on the edge that accepts
// the word, and the result sits in the output register the next cycle.
// Reset empties the row by clearing the cell valid bits; no clearing pass.
// in_stall is high only while a result waits in the output register and
// out_stall is high.
// ----------------------------------------------------------------------------
module priority_queue_remove_max_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic [pqrm_pkg::PRIO_W-1:0]  priority_req,
	input  logic signed [pqrm_pkg::DATA_W-1:0] payload,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [pqrm_pkg::STAT_W-1:0]  status,
	output logic [pqrm_pkg::PRIO_W-1:0]  out_priority,
	output logic signed [pqrm_pkg::DATA_W-1:0] out_payload
);
	import pqrm_pkg::*;

	logic              out_valid_q;
	status_t           status_q;
	logic [PRIO_W-1:0] prio_q;
	logic [DATA_W-1:0] data_q;

	logic     accept;
	logic     full;
	logic     empty;
	cell_op_t op;
	entry_t   cell_entry [DEPTH];
	logic     cell_open  [DEPTH];

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = cell_entry[DEPTH-1].valid;
	assign empty    = !cell_entry[0].valid;

	assign op.ins  = accept && (cmd == CMD_INSERT) && !full;
	assign op.rem  = accept && (cmd == CMD_REMOVE) && !empty;
	assign op.prio = priority_req;
	assign op.data = payload;

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			logic   left_o;
			if (i == 0) begin : g_first
				assign left_e = '0;
				assign left_o = 1'b0;
			end else begin : g_mid
				assign left_e = cell_entry[i-1];
				assign left_o = cell_open[i-1];
			end
			if (i == DEPTH-1) begin : g_last
				assign right_e = '0;
			end else begin : g_inner
				assign right_e = cell_entry[i+1];
			end
			pqrm_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.op          (op),
				.left_entry  (left_e),
				.left_open   (left_o),
				.right_entry (right_e),
				.entry       (cell_entry[i]),
				.open        (cell_open[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prio_q <= '0;
			data_q <= '0;
			if (cmd == CMD_INSERT) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else if (empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
				prio_q   <= cell_entry[0].prio;
				data_q   <= cell_entry[0].data;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign out_priority = prio_q;
	assign out_payload  = data_q;

endmodule

// ----- src/pqrm_cell.sv -----
// ----------------------------------------------------------------------------
// pqrm_cell: one slot of the sorted cell row
// Holds one entry. On insert it keeps its entry, takes the new one, or takes
// its left neighbor's; on remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
module pqrm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  pqrm_pkg::cell_op_t op,
	input  pqrm_pkg::entry_t  left_entry,
	input  logic              left_open,
	input  pqrm_pkg::entry_t  right_entry,
	output pqrm_pkg::entry_t  entry,
	output logic              open
);
	import pqrm_pkg::*;

	logic              valid_q;
	logic [PRIO_W-1:0] prio_q;
	logic [DATA_W-1:0] data_q;
	entry_t            nxt;
	logic              load;

	assign entry = '{valid: valid_q, prio: prio_q, data: data_q};

	// new word belongs at or before this slot
	assign open = !valid_q || (op.prio > prio_q);

	always_comb begin
		nxt  = entry;
		load = 1'b0;
		if (op.ins) begin
			if (left_open) begin
				nxt  = left_entry;
				load = 1'b1;
			end else if (open) begin
				nxt  = '{valid: 1'b1, prio: op.prio, data: op.data};
				load = 1'b1;
			end
		end else if (op.rem) begin
			nxt  = right_entry;
			load = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prio_q <= nxt.prio;
			data_q <= nxt.data;
		end
	end

endmodule
